### rtl/wht_pkg.sv
// ----------------------------------------------------------------------------
// Walsh-Hadamard transform package
// Shared constants, defaults and the sequencer state type of the transform unit.
// ----------------------------------------------------------------------------
package wht_pkg;

   localparam int FRAME_LENGTH_DEF = 256;
   localparam int SAMPLE_BITS_DEF  = 16;

   // Coefficients are plain signed integers with no fraction bits; the transform is unscaled.
   localparam int COEF_BITS    = 25;
   localparam int COEF_MAX_VAL = 16777215;
   localparam int COEF_MIN_VAL = -16777216;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_READ,
      ST_WRITE,
      ST_FLUSH
   } wht_state_type;

endpackage

### rtl/wht_if.sv
// ----------------------------------------------------------------------------
// Walsh-Hadamard transform channels
// Valid/ready channel interfaces for the sample input and coefficient output.
// ----------------------------------------------------------------------------
interface wht_req_if #(
   parameter int SAMPLE_BITS = wht_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_value;

   modport source (output valid, output sample_value, input ready);
   modport sink   (input valid, input sample_value, output ready);
endinterface

interface wht_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [wht_pkg::COEF_BITS-1:0] coefficient;
   logic                                 coefficient_valid;
   logic                                 frame_last;

   modport source (output valid, output coefficient, output coefficient_valid,
                   output frame_last, input ready);
   modport sink   (input valid, input coefficient, input coefficient_valid,
                   input frame_last, output ready);
endinterface

### rtl/walsh_hadamard_transform_unit.sv
// A sample transfer reads a coefficient into the port-A register, then the output register.
// Throughput: one sample per cycle inside a frame while the output is not stalled; after
// the last sample of a frame the block takes no samples until the transform is done, a time
// set by the single butterfly unit and the one write port of the working memory.
// Reset: synchronous; clears the control state and the frame flag, memory stays unwritten,
// and coefficients read as zero with coefficient_valid low until the first frame is done.
// ----------------------------------------------------------------------------
// Walsh-Hadamard transform unit
// Double-buffered streaming fast Walsh-Hadamard transform with an in-place sequencer.
// ----------------------------------------------------------------------------
module walsh_hadamard_transform_unit #(
   parameter int FRAME_LENGTH = wht_pkg::FRAME_LENGTH_DEF,
   parameter int SAMPLE_BITS  = wht_pkg::SAMPLE_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   wht_req_if.sink   req_channel,
   wht_rsp_if.source rsp_channel
);

   import wht_pkg::*;

   localparam int ADDR_BITS = $clog2(FRAME_LENGTH);
   localparam int WORK_BITS = SAMPLE_BITS + ADDR_BITS;
   localparam int PASS_BITS = $clog2(ADDR_BITS);
   localparam int BFLY_BITS = ADDR_BITS - 1;
   localparam int EXT_BITS  = ((WORK_BITS > COEF_BITS) ? WORK_BITS : COEF_BITS) + 1;
   localparam logic signed [EXT_BITS-1:0] COEF_MAX_EXT = EXT_BITS'(COEF_MAX_VAL);
   localparam logic signed [EXT_BITS-1:0] COEF_MIN_EXT = EXT_BITS'(COEF_MIN_VAL);

   wht_state_type state_ff, state_in;

   logic [ADDR_BITS-1:0] pos_ff, pos_in;
   logic [PASS_BITS-1:0] pass_ff, pass_in;
   logic [BFLY_BITS-1:0] bfly_ff, bfly_in;
   logic                 pend_ff, pend_in;
   logic                 bank_ff, bank_in;
   logic                 avail_ff, avail_in;
   logic [ADDR_BITS-1:0] addr_a_ff, addr_b_ff;

   logic p1_valid_ff, p1_avail_ff, p1_last_ff;
   logic p1_move;
   logic rsp_valid_ff, rsp_cvalid_ff, rsp_last_ff;
   logic signed [COEF_BITS-1:0] rsp_coef_ff;

   logic req_accept;
   logic pos_last, pass_last, bfly_last;

   logic [ADDR_BITS-1:0] idx_ext, pass_mask, pass_stride, bf_addr_a, bf_addr_b;

   logic                 wr_en, rd_en_a, rd_en_b, bfly_en;
   logic [ADDR_BITS:0]   wr_addr, rd_addr_a, rd_addr_b;
   logic [WORK_BITS-1:0] wr_data, rd_data_a, rd_data_b, bf_sum, bf_diff;

   logic signed [WORK_BITS-1:0] rd_a_signed;
   logic signed [EXT_BITS-1:0]  coef_ext;
   logic signed [COEF_BITS-1:0] coef_sat;

   wht_ram #(
      .DATA_BITS (WORK_BITS),
      .ADDR_BITS (ADDR_BITS + 1)
   ) u_ram (
      .clock        (clock),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_en_a      (rd_en_a),
      .rd_addr_a    (rd_addr_a),
      .rd_data_a_ff (rd_data_a),
      .rd_en_b      (rd_en_b),
      .rd_addr_b    (rd_addr_b),
      .rd_data_b_ff (rd_data_b)
   );

   wht_bfly #(
      .WORK_BITS (WORK_BITS)
   ) u_bfly (
      .clock     (clock),
      .en        (bfly_en),
      .operand_a (rd_data_a),
      .operand_b (rd_data_b),
      .sum       (bf_sum),
      .diff_ff   (bf_diff)
   );

   // The read register of port A doubles as the pending-result stage.
   assign p1_move           = p1_valid_ff && (!rsp_valid_ff || rsp_channel.ready);
   assign req_channel.ready = (state_ff == ST_IDLE) && (!p1_valid_ff || p1_move);
   assign req_accept        = req_channel.valid && req_channel.ready;

   assign pos_last  = (pos_ff == ADDR_BITS'(FRAME_LENGTH - 1));
   assign pass_last = (pass_ff == PASS_BITS'(ADDR_BITS - 1));
   assign bfly_last = &bfly_ff;

   // Butterfly j of a pass pairs index j with a zero inserted at the stride bit.
   assign idx_ext     = {1'b0, bfly_ff};
   assign pass_stride = ADDR_BITS'(1) << pass_ff;
   assign pass_mask   = pass_stride - ADDR_BITS'(1);
   assign bf_addr_a   = ((idx_ext & ~pass_mask) << 1) | (idx_ext & pass_mask);
   assign bf_addr_b   = bf_addr_a | pass_stride;

   assign rd_a_signed = rd_data_a;
   assign coef_ext    = EXT_BITS'(rd_a_signed);

   always_comb begin
      if (coef_ext > COEF_MAX_EXT) begin
         coef_sat = COEF_BITS'(COEF_MAX_EXT);
      end else if (coef_ext < COEF_MIN_EXT) begin
         coef_sat = COEF_BITS'(COEF_MIN_EXT);
      end else begin
         coef_sat = COEF_BITS'(coef_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      pass_in   = pass_ff;
      bfly_in   = bfly_ff;
      pend_in   = pend_ff;
      bank_in   = bank_ff;
      avail_in  = avail_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      rd_en_a   = 1'b0;
      rd_addr_a = '0;
      rd_en_b   = 1'b0;
      rd_addr_b = '0;
      bfly_en   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               // Samples fill one bank while the other bank supplies coefficients.
               wr_en     = 1'b1;
               wr_addr   = {bank_ff, pos_ff};
               wr_data   = WORK_BITS'(req_channel.sample_value);
               rd_en_a   = 1'b1;
               rd_addr_a = {~bank_ff, pos_ff};
               pos_in    = pos_ff + ADDR_BITS'(1);
               if (pos_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!p1_valid_ff || p1_move) begin
               pass_in  = '0;
               bfly_in  = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rd_en_a   = 1'b1;
            rd_addr_a = {bank_ff, bf_addr_a};
            rd_en_b   = 1'b1;
            rd_addr_b = {bank_ff, bf_addr_b};
            // The difference of the previous butterfly shares this cycle's write slot.
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = {bank_ff, addr_b_ff};
               wr_data = bf_diff;
            end
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = {bank_ff, addr_a_ff};
            wr_data = bf_sum;
            bfly_en = 1'b1;
            pend_in = 1'b1;
            bfly_in = bfly_ff + BFLY_BITS'(1);
            if (bfly_last && pass_last) begin
               state_in = ST_FLUSH;
            end else begin
               if (bfly_last) begin
                  pass_in = pass_ff + PASS_BITS'(1);
               end
               state_in = ST_READ;
            end
         end
         ST_FLUSH: begin
            wr_en    = 1'b1;
            wr_addr  = {bank_ff, addr_b_ff};
            wr_data  = bf_diff;
            pend_in  = 1'b0;
            bank_in  = ~bank_ff;
            avail_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         pass_ff  <= '0;
         bfly_ff  <= '0;
         pend_ff  <= 1'b0;
         bank_ff  <= 1'b0;
         avail_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         pass_ff  <= pass_in;
         bfly_ff  <= bfly_in;
         pend_ff  <= pend_in;
         bank_ff  <= bank_in;
         avail_ff <= avail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         addr_a_ff <= bf_addr_a;
         addr_b_ff <= bf_addr_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            p1_valid_ff <= 1'b1;
         end else if (p1_move) begin
            p1_valid_ff <= 1'b0;
         end
         if (p1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_channel.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         p1_avail_ff <= avail_ff;
         p1_last_ff  <= pos_last;
      end
      if (p1_move) begin
         rsp_coef_ff   <= p1_avail_ff ? coef_sat : '0;
         rsp_cvalid_ff <= p1_avail_ff;
         rsp_last_ff   <= p1_avail_ff && p1_last_ff;
      end
   end

   assign rsp_channel.valid             = rsp_valid_ff;
   assign rsp_channel.coefficient       = rsp_coef_ff;
   assign rsp_channel.coefficient_valid = rsp_cvalid_ff;
   assign rsp_channel.frame_last        = rsp_last_ff;

   a_last_starts_transform: assert property (@(posedge clock) disable iff (reset)
      (req_accept && pos_last) |=> (state_ff == ST_DRAIN))
      else $error("last sample of a frame did not start the transform");

   a_pending_read_held: assert property (@(posedge clock) disable iff (reset)
      (p1_valid_ff && !p1_move) |-> !rd_en_a)
      else $error("pending coefficient overwritten by a memory read");

   a_flush_has_diff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> pend_ff)
      else $error("final write slot without a pending difference");

   a_no_frame_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_cvalid_ff) |-> (rsp_coef_ff == '0 && !rsp_last_ff))
      else $error("result without a frame carries nonzero fields");

endmodule

### rtl/wht_ram.sv
// ----------------------------------------------------------------------------
// Walsh-Hadamard working memory
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module wht_ram #(
   parameter int DATA_BITS = 8,
   parameter int ADDR_BITS = 4
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en_a,
   input  logic [ADDR_BITS-1:0] rd_addr_a,
   output logic [DATA_BITS-1:0] rd_data_a_ff,
   input  logic                 rd_en_b,
   input  logic [ADDR_BITS-1:0] rd_addr_b,
   output logic [DATA_BITS-1:0] rd_data_b_ff
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en_a) begin
         rd_data_a_ff <= mem[rd_addr_a];
      end
      if (rd_en_b) begin
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

endmodule

### rtl/wht_bfly.sv
// ----------------------------------------------------------------------------
// Walsh-Hadamard butterfly
// Forms a + b for immediate write-back and holds a - b for the next write slot.
// ----------------------------------------------------------------------------
module wht_bfly #(
   parameter int WORK_BITS = 24
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [WORK_BITS-1:0] operand_a,
   input  logic [WORK_BITS-1:0] operand_b,
   output logic [WORK_BITS-1:0] sum,
   output logic [WORK_BITS-1:0] diff_ff
);

   logic [WORK_BITS-1:0] diff_in;

   // The word is wide enough for every partial sum, so wrap-around never occurs.
   assign sum     = operand_a + operand_b;
   assign diff_in = operand_a - operand_b;

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff <= diff_in;
      end
   end

endmodule

### tb/walsh_hadamard_transform_unit_tb.sv
// ----------------------------------------------------------------------------
// Walsh-Hadamard transform unit testbench
// Streams 16-bit samples into the unit and recomputes each frame's transform
// on the side. Every coefficient transfer is checked against the value that
// the previous finished frame should give. The run covers the first frame
// with no history, a full-scale negative frame, random samples with a drained
// pause, a long output stall and a gap-free stretch across a frame boundary.
// ----------------------------------------------------------------------------
module walsh_hadamard_transform_unit_tb;
   import wht_pkg::*;

   localparam int FRAME         = FRAME_LENGTH_DEF;
   localparam int SBITS         = SAMPLE_BITS_DEF;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 20;
   localparam int REPORT_LIMIT  = 10;

   localparam logic signed [SBITS-1:0] SAMPLE_MIN = {1'b1, {(SBITS-1){1'b0}}};
   localparam logic signed [SBITS-1:0] SAMPLE_MAX = {1'b0, {(SBITS-1){1'b1}}};

   typedef struct packed {
      logic signed [COEF_BITS-1:0] coefficient;
      logic                        coefficient_valid;
      logic                        frame_last;
   } coef_word_type;

   logic clock;
   logic reset;

   wht_req_if #(.SAMPLE_BITS(SBITS)) req_bus ();
   wht_rsp_if                        rsp_bus ();

   walsh_hadamard_transform_unit #(
      .FRAME_LENGTH(FRAME),
      .SAMPLE_BITS (SBITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_channel(req_bus),
      .rsp_channel(rsp_bus)
   );

   // Shadow copy of the unit: the frame being collected and the last finished transform.
   logic signed [SBITS-1:0]     frame_samples [FRAME];
   logic signed [COEF_BITS-1:0] frame_coefs   [FRAME];
   int unsigned                 frame_pos   = 0;
   bit                          coefs_ready = 1'b0;

   coef_word_type pending_coefs [$];

   int  mismatch_count      = 0;
   int  checked_count       = 0;
   int  valid_checked_count = 0;
   int  samples_sent        = 0;
   int  frames_done         = 0;
   int  cycle_count         = 0;
   int  hold_off_cycles     = 0;
   bit  sender_idling       = 1'b1;
   bit  receiver_idling     = 1'b1;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Runs the butterfly passes over the collected frame and saturates into the
   // coefficient width, as the unit does when a frame completes.
   function automatic void transform_frame();
      longint acc [FRAME];
      longint a;
      longint b;
      int     stride;
      int     base;
      int     k;
      int     n;
      for (n = 0; n < FRAME; n++) acc[n] = frame_samples[n];
      for (stride = 1; stride < FRAME; stride = stride * 2) begin
         for (base = 0; base < FRAME; base = base + 2 * stride) begin
            for (k = 0; k < stride; k++) begin
               a = acc[base + k];
               b = acc[base + k + stride];
               acc[base + k]          = a + b;
               acc[base + k + stride] = a - b;
            end
         end
      end
      for (n = 0; n < FRAME; n++) begin
         if (acc[n] > COEF_MAX_VAL) acc[n] = COEF_MAX_VAL;
         if (acc[n] < COEF_MIN_VAL) acc[n] = COEF_MIN_VAL;
         frame_coefs[n] = COEF_BITS'(acc[n]);
      end
   endfunction

   // One sample in, one coefficient of the previous frame out, or an invalid zero before any frame.
   function automatic coef_word_type predict_coefficient(input logic signed [SBITS-1:0] sample);
      coef_word_type word;
      bit            closing;
      closing = (frame_pos == FRAME - 1);
      word    = '0;
      if (coefs_ready) begin
         word.coefficient       = frame_coefs[frame_pos];
         word.coefficient_valid = 1'b1;
         word.frame_last        = closing;
      end
      frame_samples[frame_pos] = sample;
      if (closing) begin
         transform_frame();
         coefs_ready = 1'b1;
         frame_pos   = 0;
         frames_done++;
      end else begin
         frame_pos++;
      end
      return word;
   endfunction

   function automatic logic signed [SBITS-1:0] pick_sample();
      logic signed [SBITS-1:0] value;
      case ($urandom_range(0, 9))
         0:       value = SAMPLE_MIN;
         1:       value = SAMPLE_MAX;
         2, 3:    value = SBITS'(int'($urandom_range(0, 6)) - 3);
         default: value = SBITS'($urandom);
      endcase
      return value;
   endfunction

   task automatic send_sample(input logic signed [SBITS-1:0] value);
      int gap;
      if (sender_idling && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 14);
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid        <= 1'b1;
      req_bus.sample_value <= value;
      do @(posedge clock); while (!req_bus.ready);
      pending_coefs.push_back(predict_coefficient(value));
      samples_sent++;
   endtask

   task automatic release_bus();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   task automatic wait_for_results();
      while (pending_coefs.size() != 0) @(posedge clock);
   endtask

   // First frame: nothing finished yet, so every result must read as invalid zero.
   // All samples at the minimum drive coefficient 0 to the most negative sum.
   task automatic test_no_history();
      repeat (FRAME) send_sample(SAMPLE_MIN);
   endtask

   // Random samples with a full drain halfway through.
   task automatic test_random_pause();
      repeat (FRAME / 4) send_sample(pick_sample());
      release_bus();
      wait_for_results();
      repeat (FRAME / 4) send_sample(pick_sample());
   endtask

   // The receiver holds off long enough for the unit to fill and stall its input.
   task automatic test_output_stall();
      hold_off_cycles = 400;
      repeat (FRAME / 4) send_sample(pick_sample());
      release_bus();
      wait_for_results();
   endtask

   // No idling on either side; closes the second frame and runs into the third.
   task automatic test_steady_stream();
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      repeat (FRAME / 4 + $urandom_range(20, 60)) send_sample(pick_sample());
   endtask

   task automatic check_coefficient();
      coef_word_type want;
      if (pending_coefs.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("Unexpected coefficient transfer: coef=%0d valid=%0b last=%0b",
                     rsp_bus.coefficient, rsp_bus.coefficient_valid, rsp_bus.frame_last);
      end else begin
         want = pending_coefs.pop_front();
         checked_count++;
         if (want.coefficient_valid) valid_checked_count++;
         if (rsp_bus.coefficient !== want.coefficient ||
             rsp_bus.coefficient_valid !== want.coefficient_valid ||
             rsp_bus.frame_last !== want.frame_last) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("Mismatch at result %0d: expected coef=%0d valid=%0b last=%0b",
                        checked_count - 1, want.coefficient, want.coefficient_valid,
                        want.frame_last);
               $display("   got coef=%0d valid=%0b last=%0b",
                        rsp_bus.coefficient, rsp_bus.coefficient_valid,
                        rsp_bus.frame_last);
            end
         end
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) check_coefficient();
      end
   end

   initial begin
      int burst;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold_off_cycles - 1) @(negedge clock);
            hold_off_cycles = 0;
         end else if (receiver_idling && $urandom_range(0, 11) == 0) begin
            burst = $urandom_range(1, 14);
            rsp_bus.ready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_coefs.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.sample_value = '0;
      reset                = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_no_history();
      test_random_pause();
      test_output_stall();
      test_steady_stream();

      release_bus();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d samples, %0d frames transformed, %0d coefficient transfers checked",
               samples_sent, frames_done, checked_count);
      $display("%0d of those carried finished-frame data; %0d mismatches",
               valid_checked_count, mismatch_count);
      if (mismatch_count == 0 && pending_coefs.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### files.f
rtl/wht_pkg.sv
rtl/wht_if.sv
rtl/wht_ram.sv
rtl/wht_bfly.sv
rtl/walsh_hadamard_transform_unit.sv
tb/walsh_hadamard_transform_unit_tb.sv
